// ===== rtl/pngu_pkg.sv =====
// Shared types and constants for the PNG scanline unfilter.
`timescale 1ns / 1ps

package pngu_pkg;

    localparam int DATA_W      = 8;
    localparam int BPP_W       = 3;
    localparam int ROW_BYTES_W = 14;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 14;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BYTES_PER_PIXEL = 1'b0,
        REG_ROW_BYTES       = 1'b1
    } cfg_reg_t;

    // PNG filter types of filter method 0.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

endpackage

// ===== rtl/png_scanline_unfilter.sv =====
// Top level of the PNG scanline unfilter: filter type decode, prior-row store, rebuild.
`timescale 1ns / 1ps
// Path: a data word passes the input stage register and then the output register to m_tvalid.
// Throughput: one word per cycle while the consumer keeps up; filter type words are consumed and give no output word.
// The rate is set by the single pipeline of input stage, prior-row RAM read and output register.
// Reset (aresetn low, synchronous) clears the pipeline, the row state and the pixel history,
// and sets bytes_per_pixel to 4 and row_bytes to 1. The prior-row RAM is not cleared.

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pngu_pkg::DATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] image_start

    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pngu_pkg::DATA_W-1:0]       m_tdata,   // [7:0] pixel_byte
    output logic                              m_tlast,   // row_last
    output logic                              m_tuser,   // [0] bad_filter

    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pngu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Column counter addresses the prior-row RAM; the compare width also covers the
    // 14-bit row_bytes register.
    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int CMP_W  = (ADDR_W + 1 > pngu_pkg::ROW_BYTES_W) ? ADDR_W + 1
                                                                 : pngu_pkg::ROW_BYTES_W;
    localparam int PIX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int DW     = pngu_pkg::DATA_W;

    // Configuration registers.
    logic [pngu_pkg::BPP_W-1:0]       bpp_reg;
    logic [pngu_pkg::ROW_BYTES_W-1:0] row_bytes_reg;

    // Row and image state, tracked at the input side. None of it depends on the
    // rebuilt data, so it can be decoded as each word is accepted.
    logic [ADDR_W-1:0]       col_reg, col_next;
    pngu_pkg::filter_t       kind_reg, kind_next;
    logic                    await_reg, await_next;
    logic                    first_reg, first_next;
    logic                    err_reg, err_next;

    // Input stage: one data word (or one raw word while in error) on its way out.
    logic                    s1_valid_reg;
    logic [DW-1:0]           s1_byte_reg;
    logic                    s1_raw_reg;
    pngu_pkg::filter_t       s1_kind_reg;
    logic                    s1_first_reg;
    logic                    s1_last_reg;
    logic [ADDR_W-1:0]       s1_addr_reg;

    // Prior-row RAM and its registered read data.
    logic [DW-1:0]           prior_row_mem [MAX_ROW_BYTES];
    logic [DW-1:0]           rd_data_reg;

    // Pixel history: rebuilt bytes of this row and the bytes above them.
    logic [DW-1:0]           left_reg   [MAX_PIXEL_BYTES];
    logic [DW-1:0]           upleft_reg [MAX_PIXEL_BYTES];

    // Output register.
    logic                    m_valid_reg;
    logic [DW-1:0]           m_data_reg;
    logic                    m_last_reg;
    logic                    m_user_reg;

    // Handshake and control.
    logic                    out_free;
    logic                    s1_adv;
    logic                    in_accept;
    logic                    st_await, st_first, st_err;
    logic                    s1_load, s1_raw_in, s1_last_in;
    logic                    hist_clear;
    logic                    mem_re, mem_we;
    logic [CMP_W-1:0]        rb_eff;
    logic [CMP_W-1:0]        col_plus1;

    // Datapath signals.
    logic [3:0]              bpp_eff;
    logic [3:0]              bpp_m1;
    logic [PIX_W-1:0]        hist_idx;
    logic [DW-1:0]           a_val, b_val, c_val;
    logic [DW:0]             sum_ab;
    logic [DW:0]             c_twice;
    logic [DW:0]             pa, pb, pc;
    logic [DW-1:0]           paeth_pred;
    logic [DW-1:0]           pred;
    logic [DW-1:0]           recon;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken; the user only writes
    // while the block is idle.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg       <= pngu_pkg::BPP_W'(4);
            row_bytes_reg <= pngu_pkg::ROW_BYTES_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pngu_pkg::REG_BYTES_PER_PIXEL: begin
                    bpp_reg <= cfg_data[pngu_pkg::BPP_W-1:0];
                end
                pngu_pkg::REG_ROW_BYTES: begin
                    row_bytes_reg <= cfg_data[pngu_pkg::ROW_BYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Out-of-range register values are clamped into the supported range.
    always_comb begin
        rb_eff = CMP_W'(row_bytes_reg);
        if (rb_eff == '0) begin
            rb_eff = CMP_W'(1);
        end else if (rb_eff > CMP_W'(MAX_ROW_BYTES)) begin
            rb_eff = CMP_W'(MAX_ROW_BYTES);
        end
        bpp_eff = {1'b0, bpp_reg};
        if (bpp_eff == 4'd0) begin
            bpp_eff = 4'd1;
        end else if (bpp_eff > 4'(MAX_PIXEL_BYTES)) begin
            bpp_eff = 4'(MAX_PIXEL_BYTES);
        end
    end

    assign bpp_m1   = bpp_eff - 4'd1;
    assign hist_idx = bpp_m1[PIX_W-1:0];

    // ------------------------------------------------------------------
    // Handshake. The input stage moves on whenever the output register is
    // empty or being emptied, so a word is taken every cycle while the
    // consumer keeps up.
    // ------------------------------------------------------------------
    assign out_free  = !m_valid_reg || m_tready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || out_free;
    assign in_accept = s_tvalid && s_tready;

    assign col_plus1 = CMP_W'(col_reg) + CMP_W'(1);

    // Input-side decode. An image start restarts the row, the first-row flag,
    // the history and the error flag before the word is looked at. A word in
    // error passes through raw; a filter type word only updates state; a data
    // word enters the input stage and starts its prior-row read.
    always_comb begin
        col_next   = col_reg;
        kind_next  = kind_reg;
        await_next = await_reg;
        first_next = first_reg;
        err_next   = err_reg;
        s1_load    = 1'b0;
        s1_raw_in  = 1'b0;
        s1_last_in = 1'b0;
        hist_clear = 1'b0;
        mem_re     = 1'b0;

        st_await = s_tuser ? 1'b1 : await_reg;
        st_first = s_tuser ? 1'b1 : first_reg;
        st_err   = s_tuser ? 1'b0 : err_reg;

        if (in_accept) begin
            if (s_tuser) begin
                await_next = 1'b1;
                first_next = 1'b1;
                err_next   = 1'b0;
                col_next   = '0;
                hist_clear = 1'b1;
            end
            if (st_err) begin
                s1_load   = 1'b1;
                s1_raw_in = 1'b1;
            end else if (st_await) begin
                hist_clear = 1'b1;
                col_next   = '0;
                if (s_tdata > DW'(pngu_pkg::FILT_PAETH)) begin
                    err_next = 1'b1;
                end else begin
                    kind_next  = pngu_pkg::filter_t'(s_tdata[2:0]);
                    await_next = 1'b0;
                end
            end else begin
                s1_load = 1'b1;
                mem_re  = 1'b1;
                if (col_plus1 >= rb_eff) begin
                    s1_last_in = 1'b1;
                    await_next = 1'b1;
                    first_next = 1'b0;
                    col_next   = '0;
                end else begin
                    col_next = col_plus1[ADDR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            kind_reg  <= pngu_pkg::FILT_NONE;
            await_reg <= 1'b1;
            first_reg <= 1'b1;
            err_reg   <= 1'b0;
        end else begin
            col_reg   <= col_next;
            kind_reg  <= kind_next;
            await_reg <= await_next;
            first_reg <= first_next;
            err_reg   <= err_next;
        end
    end

    // ------------------------------------------------------------------
    // Input stage register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_byte_reg  <= s_tdata;
            s1_raw_reg   <= s1_raw_in;
            s1_kind_reg  <= kind_reg;
            s1_first_reg <= st_first;
            s1_last_reg  <= s1_last_in;
            s1_addr_reg  <= col_reg;
        end
    end

    // ------------------------------------------------------------------
    // Prior-row RAM. The word in the input stage writes its rebuilt byte as it
    // leaves. If a read of the same column falls on that very edge, the write
    // data is forwarded to the read.
    // ------------------------------------------------------------------
    assign mem_we = s1_adv && !s1_raw_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            prior_row_mem[s1_addr_reg] <= recon;
        end
        if (mem_re) begin
            if (mem_we && (s1_addr_reg == col_reg)) begin
                rd_data_reg <= recon;
            end else begin
                rd_data_reg <= prior_row_mem[col_reg];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rebuild. a is the byte one pixel to the left, b the byte above and c the
    // byte above-left; the first row of an image has nothing above.
    // ------------------------------------------------------------------
    assign a_val = left_reg[hist_idx];
    assign c_val = upleft_reg[hist_idx];
    assign b_val = s1_first_reg ? '0 : rd_data_reg;

    assign sum_ab  = {1'b0, a_val} + {1'b0, b_val};
    assign c_twice = {c_val, 1'b0};

    // Paeth predictor written with distances: pa = |b - c|, pb = |a - c|,
    // pc = |a + b - 2c|. Ties go to a, then b.
    always_comb begin
        pa = (b_val >= c_val) ? {1'b0, b_val - c_val} : {1'b0, c_val - b_val};
        pb = (a_val >= c_val) ? {1'b0, a_val - c_val} : {1'b0, c_val - a_val};
        pc = (sum_ab >= c_twice) ? (sum_ab - c_twice) : (c_twice - sum_ab);
        if ((pa <= pb) && (pa <= pc)) begin
            paeth_pred = a_val;
        end else if (pb <= pc) begin
            paeth_pred = b_val;
        end else begin
            paeth_pred = c_val;
        end
    end

    always_comb begin
        case (s1_kind_reg)
            pngu_pkg::FILT_SUB:   pred = a_val;
            pngu_pkg::FILT_UP:    pred = b_val;
            pngu_pkg::FILT_AVG:   pred = sum_ab[DW:1];
            pngu_pkg::FILT_PAETH: pred = paeth_pred;
            default:              pred = '0;
        endcase
    end

    assign recon = s1_byte_reg + pred;

    // History shift. A restart of the row wins over the shift of a word that
    // leaves on the same edge, because it comes later in the stream.
    always_ff @(posedge aclk) begin
        if (!aresetn || hist_clear) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                left_reg[i]   <= '0;
                upleft_reg[i] <= '0;
            end
        end else if (mem_we) begin
            for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                left_reg[i]   <= left_reg[i-1];
                upleft_reg[i] <= upleft_reg[i-1];
            end
            left_reg[0]   <= recon;
            upleft_reg[0] <= b_val;
        end
    end

    // ------------------------------------------------------------------
    // Output register. A raw word carries the error flag and never ends a row.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= s1_raw_reg ? s1_byte_reg : recon;
            m_last_reg <= s1_raw_reg ? 1'b0 : s1_last_reg;
            m_user_reg <= s1_raw_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== rtl/pngu_checker.sv =====
// Port-level assertions for the PNG scanline unfilter and their bind.
`timescale 1ns / 1ps

module pngu_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pngu_pkg::DATA_W-1:0]   m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);

    // The output register is empty after a reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word present after reset");

    // A stalled output word holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    // A raw word sent while in error never ends a row.
    a_err_no_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tlast && m_tuser))
        else $error("row end flagged on a raw error word");

    // With the output register empty the input side is always open.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (.*);
